// File: hw/rtl/lzsr_pkg.sv
// Package: shared types and constants for the LZSS ring decoder.
`timescale 1ns / 1ps

package lzsr_pkg;

   // History ring geometry
   localparam int RING_DEPTH = 4096;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam logic [RING_AW-1:0] RING_START = RING_AW'(12'hFEE);

   // Token format
   localparam int MATCH_BIAS = 3;
   localparam int COPY_CW    = 5;            // holds 3 .. 18
   localparam logic [3:0] FLAG_COUNT = 4'd8;
   localparam int LEN_W      = 32;

   // Status codes
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_SHORT = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       stream_end;
      logic       status;
   } rsp_item_type;

   // Parser phase of the compressed stream
   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_MATCH
   } phase_type;

   // Control sequencer
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COPY,
      ST_STATUS
   } state_type;

   // Ring memory access groups
   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
      logic [7:0]         data;
   } ring_wr_type;

   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
   } ring_rd_type;

endpackage

// File: hw/rtl/lzsr_ring.sv
// History ring: 4096 x 8 memory, one write port, one registered read port.
`timescale 1ns / 1ps

module lzsr_ring (
   input  logic                clock,
   input  lzsr_pkg::ring_wr_type ring_wr,
   input  lzsr_pkg::ring_rd_type ring_rd,
   output logic [7:0]          rd_data
);
   import lzsr_pkg::*;

   logic [7:0] ring_mem_ff [RING_DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (ring_wr.en) begin
         ring_mem_ff[ring_wr.addr] <= ring_wr.data;
      end
   end

   // read port, data holds while no read is issued
   always_ff @(posedge clock) begin
      if (ring_rd.en) begin
         rd_data_ff <= ring_mem_ff[ring_rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lzss_ring_decoder_top.sv
// Top level: LZSS decoder with a 4096-byte history ring.
//
//   channel  direction  handshake              item
//   req_     in         req_valid / req_stall  in_byte, in_last
//   rsp_     out        rsp_valid / rsp_stall  out_byte, run_end, stream_end, status
//   csr_     in         csr_we                 output_length (csr_wdata)
//
// A flag byte or a literal is done when it is accepted; a match second byte copies the
// n = 3 .. 18 bytes it names (fewer when the length is reached), one ring read per byte.
// A status item after a literal or a copy is emitted alone; else it goes with the input.
// Reset is synchronous and the ring is never swept: an entry not yet written in this
// stream reads as zero, judged by its distance from the start pointer vs. bytes produced.
// A stall on rsp_ freezes the sequencer; req_ is stalled while busy or the output is held.
`timescale 1ns / 1ps

module lzss_ring_decoder_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lzsr_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output lzsr_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata
);
   import lzsr_pkg::*;

   // control state
   state_type          state_ff, state_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         token_ff, token_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [7:0]         low_ff, low_in;
   logic [LEN_W-1:0]   produced_ff, produced_in;
   logic [RING_AW-1:0] wpos_ff, wpos_in;
   logic [LEN_W-1:0]   out_len_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // copy and payload state
   logic [RING_AW-1:0] copy_pos_ff, copy_pos_in;
   logic [COPY_CW-1:0] copy_cnt_ff, copy_cnt_in;
   logic               last_ff, last_in;
   logic               status_ff, status_in;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [7:0]         fwd_data_ff, fwd_data_in;
   logic               zero_ff, zero_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   // combinational
   logic               out_free;
   logic               accept;
   logic               active;
   logic [LEN_W-1:0]   produced_inc;
   logic               fin;
   logic               more;
   logic               start_copy;
   logic               go_status;
   logic               clear;
   logic               emit;
   logic [3:0]         cnt_dec;
   logic [7:0]         copy_byte;
   logic [7:0]         ring_rd_data;
   logic [RING_AW-1:0] rd_dist;
   logic               rd_filled;
   ring_wr_type        ring_wr;
   ring_rd_type        ring_rd;

   lzsr_ring u_ring (
      .clock   (clock),
      .ring_wr (ring_wr),
      .ring_rd (ring_rd),
      .rd_data (ring_rd_data)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_stall    = !((state_ff == ST_IDLE) && out_free);
   assign accept       = req_valid && !req_stall;
   assign active       = produced_ff < out_len_ff;
   assign produced_inc = produced_ff + LEN_W'(1);
   assign fin          = produced_inc == out_len_ff;
   assign cnt_dec      = (cnt_ff != 4'd0) ? cnt_ff - 4'd1 : 4'd0;

   // byte of the pending copy read: unwritten entry, same-edge write, or memory
   assign copy_byte = zero_ff    ? 8'd0 :
                      fwd_hit_ff ? fwd_data_ff : ring_rd_data;

   // fill check of the issued read against the count after this edge
   assign rd_dist   = ring_rd.addr - RING_START;
   assign rd_filled = (|produced_in[LEN_W-1:RING_AW]) ||
                      (rd_dist < produced_in[RING_AW-1:0]);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start_copy) begin
               state_in = ST_COPY;
            end else if (go_status) begin
               state_in = ST_STATUS;
            end
         end
         ST_COPY: begin
            if (out_free && !more) begin
               state_in = go_status ? ST_STATUS : ST_IDLE;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in    = phase_ff;
      token_in    = token_ff;
      cnt_in      = cnt_ff;
      low_in      = low_ff;
      produced_in = produced_ff;
      wpos_in     = wpos_ff;
      copy_pos_in = copy_pos_ff;
      copy_cnt_in = copy_cnt_ff;
      last_in     = last_ff;
      status_in   = status_ff;
      start_copy  = 1'b0;
      go_status   = 1'b0;
      clear       = 1'b0;
      more        = 1'b0;
      emit        = 1'b0;
      rsp_item_in = rsp_item_ff;
      ring_wr     = '0;
      ring_rd     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (active) begin
                  case (phase_ff)
                     PH_TOKEN: begin
                        token_in = token_ff >> 1;
                        cnt_in   = cnt_dec;
                        if (token_ff[0]) begin
                           // literal
                           ring_wr.en   = 1'b1;
                           ring_wr.addr = wpos_ff;
                           ring_wr.data = req_item.in_byte;
                           wpos_in      = wpos_ff + RING_AW'(1);
                           produced_in  = produced_inc;
                           emit         = 1'b1;
                           rsp_item_in.out_byte   = req_item.in_byte;
                           rsp_item_in.stream_end = fin;
                           rsp_item_in.status     = STATUS_OK;
                           rsp_item_in.run_end    = !(req_item.in_last && !fin);
                           phase_in = (cnt_dec != 4'd0) ? PH_TOKEN : PH_FLAG;
                           if (req_item.in_last && !fin) begin
                              go_status = 1'b1;
                              status_in = STATUS_SHORT;
                           end
                           clear = req_item.in_last;
                        end else begin
                           low_in   = req_item.in_byte;
                           phase_in = PH_MATCH;
                           if (req_item.in_last) begin
                              emit        = 1'b1;
                              rsp_item_in = '{8'd0, 1'b1, 1'b1, STATUS_SHORT};
                              clear       = 1'b1;
                           end
                        end
                     end
                     PH_MATCH: begin
                        // start the copy with the first ring read
                        ring_rd.en   = 1'b1;
                        ring_rd.addr = {req_item.in_byte[7:4], low_ff};
                        copy_pos_in  = {req_item.in_byte[7:4], low_ff};
                        copy_cnt_in  = COPY_CW'(req_item.in_byte[3:0]) + COPY_CW'(MATCH_BIAS);
                        last_in      = req_item.in_last;
                        phase_in     = (cnt_ff != 4'd0) ? PH_TOKEN : PH_FLAG;
                        start_copy   = 1'b1;
                     end
                     default: begin
                        // flag byte
                        token_in = req_item.in_byte;
                        cnt_in   = FLAG_COUNT;
                        phase_in = PH_TOKEN;
                        if (req_item.in_last) begin
                           emit        = 1'b1;
                           rsp_item_in = '{8'd0, 1'b1, 1'b1, STATUS_SHORT};
                           clear       = 1'b1;
                        end
                     end
                  endcase
               end else if (req_item.in_last) begin
                  // output already complete
                  emit        = 1'b1;
                  rsp_item_in = '{8'd0, 1'b1, 1'b1, STATUS_OK};
                  clear       = 1'b1;
               end
            end
         end
         ST_COPY: begin
            if (out_free) begin
               more         = (copy_cnt_ff != COPY_CW'(1)) && !fin;
               ring_wr.en   = 1'b1;
               ring_wr.addr = wpos_ff;
               ring_wr.data = copy_byte;
               wpos_in      = wpos_ff + RING_AW'(1);
               produced_in  = produced_inc;
               emit         = 1'b1;
               rsp_item_in.out_byte   = copy_byte;
               rsp_item_in.stream_end = fin;
               rsp_item_in.status     = STATUS_OK;
               rsp_item_in.run_end    = !more && !(last_ff && !fin);
               if (more) begin
                  ring_rd.en   = 1'b1;
                  ring_rd.addr = copy_pos_ff + RING_AW'(1);
                  copy_pos_in  = copy_pos_ff + RING_AW'(1);
                  copy_cnt_in  = copy_cnt_ff - COPY_CW'(1);
               end else begin
                  if (last_ff && !fin) begin
                     go_status = 1'b1;
                     status_in = STATUS_SHORT;
                  end
                  clear = last_ff;
               end
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               emit        = 1'b1;
               rsp_item_in = '{8'd0, 1'b1, 1'b1, status_ff};
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase

      // stream end returns the parser to its start
      if (clear) begin
         wpos_in     = RING_START;
         token_in    = 8'd0;
         cnt_in      = 4'd0;
         phase_in    = PH_FLAG;
         low_in      = 8'd0;
         produced_in = '0;
      end
   end

   // forwarding and fill flags captured with each ring read
   always_comb begin
      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      zero_in     = zero_ff;
      if (ring_rd.en) begin
         fwd_hit_in  = ring_wr.en && (ring_wr.addr == ring_rd.addr);
         fwd_data_in = ring_wr.data;
         zero_in     = !rd_filled;
      end
   end

   // output register valid
   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FLAG;
         token_ff     <= 8'd0;
         cnt_ff       <= 4'd0;
         low_ff       <= 8'd0;
         produced_ff  <= '0;
         wpos_ff      <= RING_START;
         out_len_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         token_ff     <= token_in;
         cnt_ff       <= cnt_in;
         low_ff       <= low_in;
         produced_ff  <= produced_in;
         wpos_ff      <= wpos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            out_len_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      copy_pos_ff <= copy_pos_in;
      copy_cnt_ff <= copy_cnt_in;
      last_ff     <= last_in;
      status_ff   <= status_in;
      fwd_hit_ff  <= fwd_hit_in;
      fwd_data_ff <= fwd_data_in;
      zero_ff     <= zero_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: tb/lzss_stream_checker.sv
// Checker: predicts the decoded output of each compressed item and compares results.
`timescale 1ns / 1ps

module lzss_stream_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  lzsr_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  lzsr_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic [31:0]            csr_wdata,
   output int                     fail_count,
   output int                     pending,
   output int                     checked
);
   import lzsr_pkg::*;

   // Predictor state: history window, parser and output counters
   logic [7:0]   history [0:RING_DEPTH-1];
   logic [11:0]  wr_pos;
   logic [7:0]   tok_bits;
   logic [3:0]   tok_left;
   phase_type    phase;
   logic [7:0]   pos_low;
   logic [31:0]  made;
   logic [31:0]  target_len;

   rsp_item_type expected_out[$];
   rsp_item_type step_out[$];
   rsp_item_type want;
   int           errs;
   int           seen;

   // Back to the empty-stream state; the length setting is kept
   task automatic clear_stream_state();
      foreach (history[i]) history[i] = 8'h00;
      wr_pos   = RING_START;
      tok_bits = 8'h00;
      tok_left = 4'd0;
      phase    = PH_FLAG;
      pos_low  = 8'h00;
      made     = '0;
   endtask

   // One decoded byte: into the window and onto this item's result list
   task automatic put_byte(input logic [7:0] b, output logic done);
      rsp_item_type r;
      history[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
      made   = made + 32'd1;
      done   = (made == target_len);
      r.out_byte   = b;
      r.run_end    = 1'b0;
      r.stream_end = done;
      r.status     = STATUS_OK;
      step_out.push_back(r);
   endtask

   // Expected results of one accepted compressed item
   task automatic decode_byte(input req_item_type it);
      logic         done;
      logic         lit;
      logic         d;
      logic [11:0]  src;
      int unsigned  span;
      int unsigned  k;
      rsp_item_type r;
      done = 1'b0;
      step_out.delete();
      if (made < target_len) begin
         case (phase)
            PH_TOKEN: begin
               lit      = tok_bits[0];
               tok_bits = tok_bits >> 1;
               if (tok_left != 4'd0) tok_left = tok_left - 4'd1;
               if (lit) begin
                  put_byte(it.in_byte, done);
                  phase = (tok_left != 4'd0) ? PH_TOKEN : PH_FLAG;
               end else begin
                  pos_low = it.in_byte;
                  phase   = PH_MATCH;
               end
            end
            PH_MATCH: begin
               // copy byte by byte so an overlapping match sees its own output
               src  = {it.in_byte[7:4], pos_low};
               span = it.in_byte[3:0] + MATCH_BIAS;
               for (k = 0; k < span && made < target_len; k++) begin
                  put_byte(history[src], d);
                  if (d) done = 1'b1;
                  src = src + 12'd1;
               end
               phase = (tok_left != 4'd0) ? PH_TOKEN : PH_FLAG;
            end
            default: begin
               tok_bits = it.in_byte;
               tok_left = FLAG_COUNT;
               phase    = PH_TOKEN;
            end
         endcase
      end
      // stream end that did not itself finish the output gets a status item
      if (it.in_last && !done) begin
         r.out_byte   = 8'h00;
         r.run_end    = 1'b0;
         r.stream_end = 1'b1;
         r.status     = (made < target_len) ? STATUS_SHORT : STATUS_OK;
         step_out.push_back(r);
      end
      if (step_out.size() > 0) begin
         r = step_out.pop_back();
         r.run_end = 1'b1;
         step_out.push_back(r);
      end
      foreach (step_out[i]) expected_out.push_back(step_out[i]);
      if (it.in_last) clear_stream_state();
   endtask

   // Watch all three ports at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         target_len = '0;
         clear_stream_state();
         expected_out.delete();
      end else begin
         if (csr_we) target_len = csr_wdata;
         if (req_valid && !req_stall) decode_byte(req_item);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            if (expected_out.size() == 0) begin
               $error("unexpected result item: out_byte %0h run_end %0b stream_end %0b status %0b",
                      rsp_item.out_byte, rsp_item.run_end, rsp_item.stream_end,
                      rsp_item.status);
               errs++;
            end else begin
               want = expected_out.pop_front();
               if (rsp_item.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %0h, got %0h", want.out_byte, rsp_item.out_byte);
                  errs++;
               end
               if (rsp_item.run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_item.run_end);
                  errs++;
               end
               if (rsp_item.stream_end !== want.stream_end) begin
                  $error("stream_end: expected %0b, got %0b", want.stream_end,
                         rsp_item.stream_end);
                  errs++;
               end
               if (rsp_item.status !== want.status) begin
                  $error("status: expected %0b, got %0b", want.status, rsp_item.status);
                  errs++;
               end
            end
         end
      end
      fail_count <= errs;
      pending    <= expected_out.size();
      checked    <= seen;
   end

endmodule

// File: tb/lzss_ring_decoder_top_tb.sv
// Testbench top: drives compressed streams and length settings, gives the verdict.
`timescale 1ns / 1ps

module lzss_ring_decoder_top_tb;
   import lzsr_pkg::*;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b1;
   rsp_item_type rsp_item;
   logic         csr_we    = 1'b0;
   logic [31:0]  csr_wdata = '0;

   int fail_count;
   int pending;
   int checked;

   // Stimulus bookkeeping
   logic [7:0]  pkt[$];
   logic        last_at[$];
   int unsigned made_at[$];
   int unsigned pkt_out;
   logic [31:0] cur_len;
   bit          req_calm  = 1'b0;
   bit          rsp_calm  = 1'b0;
   int          hold_asked = 0;
   int          hold_done  = 0;
   int          items_sent = 0;
   int          useful     = 0;
   int          streams    = 0;

   always #6 clock = ~clock;

   lzss_ring_decoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lzss_stream_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked)
   );

   // Offer one compressed item after a random gap; return once it is taken
   task automatic send_byte(input logic [7:0] b, input logic last);
      int           gap;
      req_item_type nxt;
      gap = req_calm ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      nxt.in_byte = b;
      nxt.in_last = last;
      req_valid <= 1'b1;
      req_item  <= nxt;
      do @(posedge clock); while (!(req_valid && !req_stall));
      items_sent++;
   endtask

   // Drain: every expected result in, then room for items that give none
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic set_length(input logic [31:0] len);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_len = len;
   endtask

   // Send the prepared stream; items past the end of output are not counted
   task automatic send_stream();
      int i;
      for (i = 0; i < pkt.size(); i++) begin
         send_byte(pkt[i], last_at[i]);
         if (made_at[i] < cur_len || last_at[i]) useful++;
      end
      streams++;
   endtask

   // Well-formed flag groups; matches mostly point just behind the write pointer
   task automatic build_stream(input int groups);
      logic [7:0]  flags;
      logic [3:0]  lenc;
      logic [11:0] src;
      logic [11:0] wp;
      int          g;
      int          k;
      pkt.delete();
      made_at.delete();
      pkt_out = 0;
      for (g = 0; g < groups; g++) begin
         flags = 8'($urandom);
         pkt.push_back(flags);
         made_at.push_back(pkt_out);
         for (k = 0; k < 8; k++) begin
            if (flags[k]) begin
               pkt.push_back(8'($urandom));
               made_at.push_back(pkt_out);
               pkt_out++;
            end else begin
               wp   = RING_START + 12'(pkt_out);
               src  = ($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                  : wp - 12'($urandom_range(1, 24));
               lenc = 4'($urandom_range(0, 15));
               pkt.push_back(src[7:0]);
               made_at.push_back(pkt_out);
               pkt.push_back({src[11:8], lenc});
               made_at.push_back(pkt_out);
               pkt_out += lenc + MATCH_BIAS;
            end
         end
      end
   endtask

   task automatic mark_end_only();
      last_at.delete();
      foreach (pkt[i]) last_at.push_back(i == pkt.size() - 1);
   endtask

   // Directed stream from a fixed byte list
   task automatic load_bytes(input logic [7:0] bytes[$], input bit ends);
      pkt     = bytes;
      made_at.delete();
      foreach (pkt[i]) made_at.push_back(0);
      last_at.delete();
      foreach (pkt[i]) last_at.push_back(ends && i == pkt.size() - 1);
   endtask

   // Receiver: random stalls, quiet stretches, and one long hold-off on request
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_asked != hold_done) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            hold_done++;
         end
         gap = rsp_calm ? 0 : $urandom_range(0, 8);
         rsp_stall <= (gap != 0);
         if (gap != 0) begin
            repeat (gap) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Run limit
   initial begin
      #5ms;
      $display("lzss_ring_decoder_top_tb NOT OK");
      $finish;
   end

   // Main stimulus
   initial begin
      int          kind;
      int          cut;
      int          w;
      int unsigned tot;
      logic [31:0] len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero length: everything ignored, stream end gives an ok status
      set_length(32'd0);
      load_bytes('{8'hFF, 8'h00}, 1'b1);
      send_stream();

      // huge length: literal extremes, overlapping match across the wrap,
      // match from unwritten entries, then an early end with short status
      set_length(32'hFFFF_FFFF);
      load_bytes('{8'h13, 8'hFF, 8'h00, 8'hEE, 8'hFF, 8'h00, 8'h80, 8'hA5}, 1'b1);
      send_stream();

      // match cut short at the length; later bytes ignored; cleared window
      set_length(32'd5);
      load_bytes('{8'h00, 8'hEE, 8'hFF, 8'h12, 8'h34}, 1'b1);
      send_stream();

      // last byte that itself completes the output: no status item
      set_length(32'd1);
      load_bytes('{8'h01, 8'h77}, 1'b1);
      send_stream();

      // length lowered below the bytes already produced in mid-stream
      set_length(32'd10);
      load_bytes('{8'hFF, 8'h01, 8'h02, 8'h03}, 1'b0);
      send_stream();
      set_length(32'd2);
      load_bytes('{8'h04, 8'h05}, 1'b1);
      send_stream();
      useful = 0;

      // Random streams: mostly well formed, some truncated, some noise
      while (useful < 250) begin
         kind = $urandom_range(0, 9);
         if (streams == 9) begin
            build_stream(5);
            mark_end_only();
         end else if (kind == 0) begin
            cut = $urandom_range(1, 10);
            pkt.delete();
            made_at.delete();
            last_at.delete();
            repeat (cut) begin
               pkt.push_back(8'($urandom));
               made_at.push_back(0);
               last_at.push_back($urandom_range(0, 5) == 0);
            end
            last_at[cut - 1] = 1'b1;
            pkt_out = $urandom_range(0, 40);
         end else begin
            build_stream(($urandom_range(0, 9) == 0) ? $urandom_range(4, 6)
                                                     : $urandom_range(1, 3));
            if (kind == 1) begin
               cut = $urandom_range(1, pkt.size());
               while (pkt.size() > cut) begin
                  void'(pkt.pop_back());
                  void'(made_at.pop_back());
               end
            end
            mark_end_only();
         end

         tot = pkt_out;
         case ($urandom_range(0, 9))
            0:       len = 32'd0;
            1:       len = 32'hFFFF_FFFF;
            2, 3:    len = tot - $urandom_range(0, tot);
            4, 5:    len = tot + $urandom_range(1, 8);
            default: len = tot;
         endcase
         if (streams == 9) len = 32'hFFFF_FFFF;
         if (streams == 9 || $urandom_range(0, 3) != 0) set_length(len);

         req_calm = ($urandom_range(0, 4) == 0);
         rsp_calm = ($urandom_range(0, 4) == 0);
         if (streams == 9) begin
            // receiver holds off while the sender keeps offering
            req_calm = 1'b1;
            hold_asked++;
         end
         send_stream();
      end

      // Drain and let any stray result show up
      req_valid <= 1'b0;
      @(posedge clock);
      for (w = 0; w < 20000 && pending != 0; w++) @(posedge clock);
      repeat (40) @(posedge clock);

      if (pending != 0) $error("%0d expected result items never arrived", pending);
      $display("Run: %0d compressed items in %0d streams, %0d decoded items checked,",
               items_sent, streams, checked);
      $display("     lengths from zero to all ones, truncated and noisy streams included.");
      if (fail_count == 0 && pending == 0) begin
         $display("lzss_ring_decoder_top_tb OK");
      end else begin
         $display("lzss_ring_decoder_top_tb NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/lzsr_pkg.sv
hw/rtl/lzsr_ring.sv
hw/rtl/lzss_ring_decoder_top.sv
tb/lzss_stream_checker.sv
tb/lzss_ring_decoder_top_tb.sv
